@@ rtl/stq_pkg.sv @@
// Shared types and constants of the sorted timer queue.
`timescale 1ns / 1ps

package stq_pkg;

    // Item commands
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_TAKE   = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One table entry as stored in the memory
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] timeout;
        logic [7:0]  owner;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Controller to datapath commands
    typedef struct packed {
        logic latch;      // capture the accepted item
        logic res_full;   // stage a table-full result
        logic res_empty;  // stage an empty-queue result
        logic cmp_rd;     // compaction: first read
        logic cmp_mv;     // compaction: write one entry down, read next
        logic cmp_fin;    // compaction: rebase head and end
        logic shf_start;  // shift: load pointer from end, read end-1
        logic shf_mv;     // shift: move one entry up, read next lower
        logic ins_wr;     // write the new entry at the pointer
        logic take_rd;    // read the head entry
        logic take_out;   // stage the head entry and advance head
        logic out_load;   // move staged result into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic end_full;     // end index at capacity
        logic head_big;     // more than one entry consumed
        logic queue_empty;  // head equals end
        logic cmp_done;     // nothing left to compact
        logic cmp_last;     // entry being moved is the last live one
        logic key_less;     // entry read has a later timeout than the key
        logic shf_last;     // entry being moved is the head entry
        logic out_free;     // output register can take a result
    } t_dp_status;

endpackage

@@ rtl/stq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module stq_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/stq_ctrl.sv @@
// Controller state machine of the sorted timer queue.
`timescale 1ns / 1ps

module stq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_cmd,
    input  stq_pkg::t_dp_status i_stat,
    output logic                o_in_ready,
    output stq_pkg::t_dp_cmd    o_cmd
);
    import stq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_CMP_RD  = 9'b000000010,
        S_CMP_MV  = 9'b000000100,
        S_SHF_RD  = 9'b000001000,
        S_SHF_MV  = 9'b000010000,
        S_INS_WR  = 9'b000100000,
        S_TAKE    = 9'b001000000,
        S_TAKE_WT = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    if (i_cmd == CMD_TAKE) begin
                        n_state = S_TAKE;
                    end else if (i_stat.end_full) begin
                        if (i_stat.head_big) begin
                            n_state = S_CMP_RD;
                        end else begin
                            o_cmd.res_full = 1'b1;
                            n_state        = S_DONE;
                        end
                    end else begin
                        n_state = S_SHF_RD;
                    end
                end
            end
            S_CMP_RD: begin
                if (i_stat.cmp_done) begin
                    o_cmd.cmp_fin = 1'b1;
                    n_state       = S_SHF_RD;
                end else begin
                    o_cmd.cmp_rd = 1'b1;
                    n_state      = S_CMP_MV;
                end
            end
            S_CMP_MV: begin
                o_cmd.cmp_mv = 1'b1;
                if (i_stat.cmp_last) begin
                    o_cmd.cmp_fin = 1'b1;
                    n_state       = S_SHF_RD;
                end
            end
            S_SHF_RD: begin
                o_cmd.shf_start = 1'b1;
                n_state = i_stat.queue_empty ? S_INS_WR : S_SHF_MV;
            end
            S_SHF_MV: begin
                // Walk down while entries sort after the new key
                if (i_stat.key_less) begin
                    o_cmd.shf_mv = 1'b1;
                    if (i_stat.shf_last) begin
                        n_state = S_INS_WR;
                    end
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.ins_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_TAKE: begin
                if (i_stat.queue_empty) begin
                    o_cmd.res_empty = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.take_rd = 1'b1;
                    n_state       = S_TAKE_WT;
                end
            end
            S_TAKE_WT: begin
                o_cmd.take_out = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/stq_datapath.sv @@
// Datapath of the sorted timer queue: indexes, entry memory and result registers.
`timescale 1ns / 1ps

module stq_datapath #(
    parameter int DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stq_pkg::t_dp_cmd    i_cmd,
    output stq_pkg::t_dp_status o_stat,
    input  logic [31:0]         i_timeout,
    input  logic [7:0]          i_owner,
    input  logic [31:0]         i_now,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [1:0]          o_status,
    output logic [7:0]          o_slot,
    output logic [31:0]         o_entry_start,
    output logic [31:0]         o_entry_timeout,
    output logic [7:0]          o_entry_owner
);
    import stq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    logic [CW-1:0] r_head, r_end, r_ptr;
    logic [31:0]   r_key, r_now;
    logic [7:0]    r_owner;
    t_status       r_res_status;
    logic [CW-1:0] r_res_slot;
    t_entry        r_res_entry;
    logic          r_out_valid;
    t_status       r_out_status;
    logic [7:0]    r_out_slot;
    t_entry        r_out_entry;

    logic [CW-1:0]    live;
    logic [CW-1:0]    rd_addr_full, wr_addr_full;
    logic             rd_en, wr_en;
    t_entry           wr_data, rd_data;
    logic [ENTRY_W-1:0] rd_bits;
    logic [CW+7:0]    res_slot_ext;

    assign live    = r_end - r_head;
    assign rd_data = t_entry'(rd_bits);

    // Memory port selection; the commands are mutually exclusive per port
    always_comb begin
        rd_en        = 1'b0;
        rd_addr_full = '0;
        wr_en        = 1'b0;
        wr_addr_full = r_ptr;
        wr_data      = rd_data;
        if (i_cmd.cmp_rd) begin
            rd_en        = 1'b1;
            rd_addr_full = r_ptr + r_head;
        end
        if (i_cmd.cmp_mv) begin
            wr_en        = 1'b1;
            rd_en        = 1'b1;
            rd_addr_full = r_ptr + r_head + CW'(1);
        end
        if (i_cmd.shf_start) begin
            rd_en        = 1'b1;
            rd_addr_full = r_end - CW'(1);
        end
        if (i_cmd.shf_mv) begin
            wr_en        = 1'b1;
            rd_en        = 1'b1;
            rd_addr_full = r_ptr - CW'(2);
        end
        if (i_cmd.ins_wr) begin
            wr_en   = 1'b1;
            wr_data = '{start: r_now, timeout: r_key, owner: r_owner};
        end
        if (i_cmd.take_rd) begin
            rd_en        = 1'b1;
            rd_addr_full = r_head;
        end
    end

    stq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr_full[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr_full[AW-1:0]),
        .o_rd_data (rd_bits)
    );

    // Status toward the controller
    always_comb begin
        o_stat.end_full    = (r_end == CW'(DEPTH));
        o_stat.head_big    = (r_head > CW'(1));
        o_stat.queue_empty = (r_head == r_end);
        o_stat.cmp_done    = (r_ptr == live);
        o_stat.cmp_last    = ((r_ptr + CW'(1)) == live);
        o_stat.key_less    = (rd_data.timeout > r_key);
        o_stat.shf_last    = (r_ptr == (r_head + CW'(1)));
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    // Head, end and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_end       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cmp_fin) begin
                r_end  <= live;
                r_head <= '0;
            end
            if (i_cmd.ins_wr) begin
                r_end <= r_end + CW'(1);
            end
            if (i_cmd.take_out) begin
                r_head <= r_head + CW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item, pointer and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_key   <= i_timeout;
            r_owner <= i_owner;
            r_now   <= i_now;
            r_ptr   <= '0;
        end
        if (i_cmd.cmp_mv) begin
            r_ptr <= r_ptr + CW'(1);
        end
        if (i_cmd.shf_start) begin
            r_ptr <= r_end;
        end
        if (i_cmd.shf_mv) begin
            r_ptr <= r_ptr - CW'(1);
        end
        if (i_cmd.ins_wr) begin
            r_res_status <= ST_DONE;
            r_res_slot   <= r_ptr;
            r_res_entry  <= '0;
        end
        if (i_cmd.res_full) begin
            r_res_status <= ST_FULL;
            r_res_slot   <= '0;
            r_res_entry  <= '0;
        end
        if (i_cmd.res_empty) begin
            r_res_status <= ST_EMPTY;
            r_res_slot   <= '0;
            r_res_entry  <= '0;
        end
        if (i_cmd.take_out) begin
            r_res_status <= ST_DONE;
            r_res_slot   <= r_head;
            r_res_entry  <= rd_data;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= res_slot_ext[7:0];
            r_out_entry  <= r_res_entry;
        end
    end

    // Slot number reported as its low eight bits
    assign res_slot_ext = (CW + 8)'(r_res_slot);

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_slot          = r_out_slot;
    assign o_entry_start   = r_out_entry.start;
    assign o_entry_timeout = r_out_entry.timeout;
    assign o_entry_owner   = r_out_entry.owner;

endmodule

@@ rtl/sorted_timer_queue_unit.sv @@
// Top level of the sorted timer queue.
//
//   channel | handshake                | payload
//   --------+--------------------------+---------------------------------------------
//   in      | i_in_valid / o_in_ready  | i_cmd, i_timeout, i_owner, i_now
//   out     | o_out_valid / i_out_ready| o_status, o_slot, o_entry_start,
//           |                          | o_entry_timeout, o_entry_owner
//
// One item at a time; the input is ready only while the controller is idle.
// Take: S_TAKE, S_TAKE_WT, then S_DONE (empty: S_TAKE, S_DONE). Rejected insert: straight to S_DONE.
// Insert: S_SHF_RD, S_SHF_MV while entries are moved up one slot, S_INS_WR, then S_DONE;
// when compaction runs, S_CMP_RD and S_CMP_MV first move the live entries down.
// Insert time grows with the entries moved, one per write of the one memory write port.
// Reset clears head, end and the controller; the entry memory is not cleared.
// A result waiting on i_out_ready does not block the next item until its own
// result is ready.
`timescale 1ns / 1ps

module sorted_timer_queue_unit #(
    parameter int DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [31:0] i_timeout,
    input  logic [7:0]  i_owner,
    input  logic [31:0] i_now,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_slot,
    output logic [31:0] o_entry_start,
    output logic [31:0] o_entry_timeout,
    output logic [7:0]  o_entry_owner
);
    import stq_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_stat;

    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_stat     (dp_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd)
    );

    stq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_timeout       (i_timeout),
        .i_owner         (i_owner),
        .i_now           (i_now),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_entry_start   (o_entry_start),
        .o_entry_timeout (o_entry_timeout),
        .o_entry_owner   (o_entry_owner)
    );

endmodule

@@ rtl/stq_checker.sv @@
// Port-level checks of the sorted timer queue, bound to the top level.
`timescale 1ns / 1ps

module stq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_cmd,
    input logic [31:0] i_timeout,
    input logic [7:0]  i_owner,
    input logic [31:0] i_now,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [7:0]  o_slot,
    input logic [31:0] o_entry_start,
    input logic [31:0] o_entry_timeout,
    input logic [7:0]  o_entry_owner
);
    import stq_pkg::*;

    // No result is shown right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // An accepted item closes the input in the following cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    // A waiting input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_cmd) &&
            $stable(i_timeout) && $stable(i_owner) && $stable(i_now))
        else $error("waiting input item changed");

    // Rejected or empty results carry no slot and no entry
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL || o_status == ST_EMPTY) |->
            o_slot == 8'd0 && o_entry_start == 32'd0 &&
            o_entry_timeout == 32'd0 && o_entry_owner == 8'd0)
        else $error("non-done result with payload");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) &&
            $stable(o_slot) && $stable(o_entry_start) &&
            $stable(o_entry_timeout) && $stable(o_entry_owner))
        else $error("stalled result changed");

endmodule

bind sorted_timer_queue_unit stq_checker u_stq_checker (.*);

@@ dv/testbench.sv @@
// Self-checking testbench for the sorted timer queue: random insert/take traffic, scoreboard.
`timescale 1ns / 1ps

module testbench;
    import stq_pkg::*;

    localparam int TQ_DEPTH       = 256;
    localparam int ITEM_TARGET    = 1100;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        cmd;
        logic [31:0] timeout;
        logic [7:0]  owner;
        logic [31:0] now;
    } t_timer_op;

    typedef struct packed {
        t_status     status;
        logic [7:0]  slot;
        logic [31:0] start;
        logic [31:0] timeout;
        logic [7:0]  owner;
    } t_timer_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_cmd = 1'b0;
    logic [31:0] i_timeout = '0;
    logic [7:0]  i_owner = '0;
    logic [31:0] i_now = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_slot;
    logic [31:0] o_entry_start;
    logic [31:0] o_entry_timeout;
    logic [7:0]  o_entry_owner;

    // Shadow timer table and indexes
    t_entry tq_tab[TQ_DEPTH];
    int     tq_head = 0;
    int     tq_end = 0;

    t_timer_op    timer_ops_q[$];
    t_timer_reply replies_due[$];
    t_timer_op    cur_op;

    int send_idle_pct = 34;
    int recv_idle_pct = 75;
    int hold_req = 0;
    int hold_served = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    int err_count = 0;
    int n_items = 0;

    sorted_timer_queue_unit #(.DEPTH(TQ_DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_timeout       (i_timeout),
        .i_owner         (i_owner),
        .i_now           (i_now),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_entry_start   (o_entry_start),
        .o_entry_timeout (o_entry_timeout),
        .o_entry_owner   (o_entry_owner)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one op to the shadow table and return the reply it should produce
    function automatic t_timer_reply table_update(t_timer_op op);
        t_timer_reply rep;
        int pos;
        int live;
        rep = '0;
        if (op.cmd == CMD_INSERT) begin
            // full table with enough consumed entries: slide live ones down to 0
            if (tq_end == TQ_DEPTH && tq_head > 1) begin
                live = tq_end - tq_head;
                for (int k = 0; k < live; k++) tq_tab[k] = tq_tab[k + tq_head];
                tq_end = live;
                tq_head = 0;
            end
            if (tq_end == TQ_DEPTH) begin
                rep.status = ST_FULL;
            end else begin
                // new entry goes after every entry with equal or smaller timeout
                pos = tq_head;
                while (pos < tq_end && tq_tab[pos].timeout <= op.timeout) pos++;
                for (int k = tq_end; k > pos; k--) tq_tab[k] = tq_tab[k - 1];
                tq_tab[pos] = '{start: op.now, timeout: op.timeout, owner: op.owner};
                tq_end++;
                rep.slot = pos[7:0];
            end
        end else if (tq_head == tq_end) begin
            rep.status = ST_EMPTY;
        end else begin
            rep.slot    = tq_head[7:0];
            rep.start   = tq_tab[tq_head].start;
            rep.timeout = tq_tab[tq_head].timeout;
            rep.owner   = tq_tab[tq_head].owner;
            tq_head++;
        end
        return rep;
    endfunction

    // Sort keys: many small values so equal timeouts are common
    function automatic logic [31:0] pick_timeout();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2, 3, 4: return $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_fixed(input logic cmd, input logic [31:0] timeout,
                             input logic [7:0] owner, input logic [31:0] now);
        timer_ops_q.push_back('{cmd: cmd, timeout: timeout, owner: owner, now: now});
        n_items++;
    endtask

    task automatic add_op(input logic cmd);
        logic [31:0] now;
        case ($urandom_range(0, 15))
            0:       now = 32'h0;
            1:       now = 32'hFFFF_FFFF;
            default: now = $urandom;
        endcase
        add_fixed(cmd, pick_timeout(), 8'($urandom_range(0, 255)), now);
    endtask

    // Wait until every queued op has been accepted
    task automatic wait_sent();
        while (timer_ops_q.size() != 0 || i_in_valid) @(negedge i_clk);
    endtask

    // Wait until every reply has also come back
    task automatic wait_quiet();
        wait_sent();
        while (replies_due.size() != 0) @(negedge i_clk);
    endtask

    // Driver: predict on accept, then present the next op unless idling
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) replies_due.push_back(table_update(cur_op));
            if (!i_in_valid || o_in_ready) begin
                if (timer_ops_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_op = timer_ops_q.pop_front();
                    i_cmd      <= cur_op.cmd;
                    i_timeout  <= cur_op.timeout;
                    i_owner    <= cur_op.owner;
                    i_now      <= cur_op.now;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_served != hold_req) begin
            hold_served <= hold_req;
            hold_left   <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compare each reply with the oldest prediction
    always @(posedge i_clk) begin
        t_timer_reply got;
        t_timer_reply exp;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = '{status: t_status'(o_status), slot: o_slot, start: o_entry_start,
                        timeout: o_entry_timeout, owner: o_entry_owner};
                if (replies_due.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected reply: status %0d slot %0d", o_status, o_slot);
                end else begin
                    exp = replies_due.pop_front();
                    if (got !== exp) begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"mismatch (exp/got): status %0d/%0d slot %0d/%0d ",
                                      "start %h/%h timeout %h/%h owner %h/%h"},
                                     exp.status, got.status, exp.slot, got.slot,
                                     exp.start, got.start, exp.timeout, got.timeout,
                                     exp.owner, got.owner);
                    end
                end
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        int phase;
        int next_phase;
        int pick;
        phase = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty take, field extremes, equal timeouts, one take
        add_fixed(CMD_TAKE,   32'h0000_0000, 8'h00, 32'h0000_0000);
        add_fixed(CMD_INSERT, 32'd100,       8'h01, 32'h0000_0000);
        add_fixed(CMD_INSERT, 32'h0000_0000, 8'hFF, 32'hFFFF_FFFF);
        add_fixed(CMD_INSERT, 32'hFFFF_FFFF, 8'h00, 32'h0000_0000);
        add_fixed(CMD_INSERT, 32'd100,       8'h02, 32'h0000_0001);
        add_fixed(CMD_INSERT, 32'd100,       8'h03, 32'h0000_0002);
        add_fixed(CMD_INSERT, 32'hAAAA_AAAA, 8'hAA, 32'h5555_5555);
        add_fixed(CMD_INSERT, 32'h5555_5555, 8'h55, 32'hAAAA_AAAA);
        add_fixed(CMD_TAKE,   32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        wait_quiet();

        // fill to capacity with head at 1 while the receiver holds off,
        // then full rejects, one more take, and an insert that compacts
        hold_req++;
        repeat (TQ_DEPTH - tq_end + 3) add_op(CMD_INSERT);
        add_op(CMD_TAKE);
        repeat (2) add_op(CMD_INSERT);

        while (n_items < ITEM_TARGET) begin
            wait_sent();
            next_phase = (n_items < 370) ? 0 : (n_items < 740) ? 1 : 2;
            if (next_phase != phase) begin
                wait_quiet();
                phase = next_phase;
                send_idle_pct = (phase == 1) ? 75 : 0;
                recv_idle_pct = (phase == 1) ? 34 : 0;
                if (phase == 2) hold_req++;
            end
            pick = $urandom_range(0, 99);
            // keep the table-long bursts away from the end of the run
            if (pick >= 62 && pick < 82 && n_items + TQ_DEPTH > ITEM_TARGET) pick = 90;
            if (pick < 40) begin
                repeat ($urandom_range(1, 40)) add_op(CMD_INSERT);
            end else if (pick < 62) begin
                repeat ($urandom_range(1, 30)) add_op(CMD_TAKE);
            end else if (pick < 72) begin
                // drain past empty
                wait_quiet();
                repeat (tq_end - tq_head + $urandom_range(1, 2)) add_op(CMD_TAKE);
            end else if (pick < 82) begin
                // run into the end of the table: compaction or full
                repeat (TQ_DEPTH - tq_end + $urandom_range(1, 3)) add_op(CMD_INSERT);
            end else begin
                repeat ($urandom_range(5, 20))
                    add_op(($urandom_range(0, 1) == 0) ? CMD_INSERT : CMD_TAKE);
            end
        end

        wait_quiet();
        repeat (100) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
